// ===== rtl/core/fpw_pkg.sv =====
// Shared types, codes and helpers for the four-level page table walker.
package fpw_pkg;

	localparam int ENTRY_W           = 64;
	localparam int VA_W              = 48;
	localparam int PA_W              = 52;
	localparam int IDX_W             = 9;
	localparam int OFF_W             = 12;
	localparam int ENTRIES_PER_TABLE = 512;

	typedef logic [1:0] mode_t;
	typedef logic [1:0] status_t;

	localparam mode_t MODE_TRANSLATE = 2'd0;
	localparam mode_t MODE_MAP       = 2'd1;
	localparam mode_t MODE_UNMAP     = 2'd2;
	localparam mode_t MODE_RSVD      = 2'd3;

	localparam status_t ST_DONE       = 2'd0;
	localparam status_t ST_UNMAPPED   = 2'd1;
	localparam status_t ST_POOL_EMPTY = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    clear;
		logic    zero;
		logic    capture;
		logic    rd;
		logic    follow;
		logic    link;
		logic    wr_leaf;
		logic    set_trans;
		logic    result;
		status_t status;
	} fpw_cmd_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		logic  clr_last;
		logic  zero_last;
		mode_t mode;
		logic  link_ok;
		logic  leaf_present;
		logic  pool_empty;
		logic  last_upper;
		logic  out_free;
	} fpw_sts_t;

	// Table index for one radix level, level 0 being the root.
	function automatic logic [IDX_W-1:0] level_index(input logic [VA_W-1:0] va,
		input logic [1:0] lvl);
		logic [IDX_W-1:0] idx;
		case (lvl)
			2'd0: idx = va[47:39];
			2'd1: idx = va[38:30];
			2'd2: idx = va[29:21];
			default: idx = va[20:12];
		endcase
		return idx;
	endfunction

endpackage

// ===== rtl/core/fpw_ctrl.sv =====
// Controller state machine that sequences clearing, level walks and result hand-off.
module fpw_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_valid,
	output logic            s_ready,
	input  fpw_pkg::fpw_sts_t sts,
	output fpw_pkg::fpw_cmd_t cmd
);
	import fpw_pkg::*;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_EVAL,
		S_ZERO,
		S_LINK,
		S_LEAF,
		S_LEAF_EVAL,
		S_DONE
	} state_t;

	state_t  state_q;
	status_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			res_q   <= ST_DONE;
		end else begin
			case (state_q)
				S_CLEAR: begin
					if (sts.clr_last) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (s_valid) begin
						res_q   <= ST_DONE;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					// The reserved mode touches nothing and reports done.
					if (sts.mode == MODE_RSVD) state_q <= S_DONE;
					else state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (sts.link_ok) begin
						state_q <= sts.last_upper ? S_LEAF : S_READ;
					end else if (sts.mode == MODE_TRANSLATE) begin
						res_q   <= ST_UNMAPPED;
						state_q <= S_DONE;
					end else if (sts.pool_empty) begin
						res_q   <= ST_POOL_EMPTY;
						state_q <= S_DONE;
					end else begin
						state_q <= S_ZERO;
					end
				end
				S_ZERO: begin
					// The new page is cleared before the link to it is written.
					if (sts.zero_last) state_q <= S_LINK;
				end
				S_LINK: begin
					state_q <= sts.last_upper ? S_LEAF : S_READ;
				end
				S_LEAF: begin
					if (sts.mode == MODE_TRANSLATE) state_q <= S_LEAF_EVAL;
					else state_q <= S_DONE;
				end
				S_LEAF_EVAL: begin
					if (!sts.leaf_present) res_q <= ST_UNMAPPED;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (sts.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_ready = (state_q == S_IDLE);

	always_comb begin
		cmd           = '0;
		cmd.clear     = (state_q == S_CLEAR);
		cmd.zero      = (state_q == S_ZERO);
		cmd.capture   = (state_q == S_IDLE) && s_valid;
		cmd.rd        = (state_q == S_READ) ||
		                ((state_q == S_LEAF) && (sts.mode == MODE_TRANSLATE));
		cmd.follow    = (state_q == S_EVAL) && sts.link_ok;
		cmd.link      = (state_q == S_LINK);
		cmd.wr_leaf   = (state_q == S_LEAF) && (sts.mode != MODE_TRANSLATE);
		cmd.set_trans = (state_q == S_LEAF_EVAL) && sts.leaf_present;
		cmd.result    = (state_q == S_DONE) && sts.out_free;
		cmd.status    = res_q;
	end

endmodule

// ===== rtl/core/fpw_dp.sv =====
// Datapath: table memory, request registers, level and pool counters, result register.
module fpw_dp #(
	parameter int TABLE_PAGES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [fpw_pkg::PA_W-1:0]      cfg_wr_data,
	input  logic [1:0]                    mode,
	input  logic [fpw_pkg::VA_W-1:0]      virt_addr,
	input  logic [fpw_pkg::PA_W-1:0]      target_phys,
	input  logic [fpw_pkg::ENTRY_W-1:0]   entry_flags,
	input  fpw_pkg::fpw_cmd_t             cmd,
	output fpw_pkg::fpw_sts_t             sts,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [1:0]                    out_status,
	output logic [fpw_pkg::ENTRY_W-1:0]   out_translated
);
	import fpw_pkg::*;

	localparam int PW    = $clog2(TABLE_PAGES);
	localparam int NFW   = $clog2(TABLE_PAGES + 1);
	localparam int AW    = PW + IDX_W;
	localparam int DEPTH = TABLE_PAGES * ENTRIES_PER_TABLE;
	localparam int FW    = PA_W - OFF_W;
	localparam int LW    = ENTRY_W - OFF_W;

	logic [ENTRY_W-1:0] mem [DEPTH];

	logic [PA_W-1:0]    base_q;
	mode_t              mode_q;
	logic [VA_W-1:0]    va_q;
	logic [PA_W-1:0]    phys_q;
	logic [ENTRY_W-1:0] flags_q;
	logic [1:0]         level_q;
	logic [PW-1:0]      cur_q;
	logic [NFW-1:0]     next_free_q;
	logic [AW-1:0]      clr_cnt_q;
	logic [ENTRY_W-1:0] rd_q;
	logic [ENTRY_W-1:0] trans_q;
	logic               out_valid_q;
	status_t            out_status_q;
	logic [ENTRY_W-1:0] out_data_q;

	logic [AW-1:0]      slot;
	logic [LW-1:0]      link_diff;
	logic [FW:0]        link_page;
	logic [ENTRY_W-1:0] link_word;
	logic [ENTRY_W-1:0] leaf_word;
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [ENTRY_W-1:0] mem_wdata;

	assign slot = {cur_q, level_index(va_q, level_q)};

	// A link is followed only when it lands on a pool page relative to the current base.
	assign link_diff = rd_q[ENTRY_W-1:OFF_W] - {{(LW-FW){1'b0}}, base_q[PA_W-1:OFF_W]};
	assign link_page = {1'b0, base_q[PA_W-1:OFF_W]} + (FW+1)'(next_free_q);
	assign link_word = {{(ENTRY_W-FW-1-OFF_W){1'b0}}, link_page, {(OFF_W-2){1'b0}}, 2'b11};
	assign leaf_word = (mode_q == MODE_MAP) ?
		({{(ENTRY_W-PA_W){1'b0}}, phys_q[PA_W-1:OFF_W], {OFF_W{1'b0}}} |
		 flags_q | ENTRY_W'(1)) : '0;

	// The sweep counter ends every pass with its entry bits at zero, so the page
	// clear for a new level reuses its low bits as the entry index.
	always_comb begin
		mem_we    = cmd.clear || cmd.zero || cmd.link || cmd.wr_leaf;
		mem_waddr = slot;
		mem_wdata = '0;
		if (cmd.clear) begin
			mem_waddr = clr_cnt_q;
		end else if (cmd.zero) begin
			mem_waddr = {next_free_q[PW-1:0], clr_cnt_q[IDX_W-1:0]};
		end else if (cmd.link) begin
			mem_wdata = link_word;
		end else begin
			mem_wdata = leaf_word;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (cmd.rd) rd_q <= mem[slot];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q  <= mode;
			va_q    <= virt_addr;
			phys_q  <= target_phys;
			flags_q <= entry_flags;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q       <= '0;
			level_q      <= '0;
			cur_q        <= '0;
			next_free_q  <= NFW'(1);
			clr_cnt_q    <= '0;
			trans_q      <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_DONE;
			out_data_q   <= '0;
		end else begin
			if (cfg_wr_en) base_q <= cfg_wr_data;
			if (cmd.clear || cmd.zero) clr_cnt_q <= clr_cnt_q + AW'(1);
			if (cmd.capture) begin
				level_q <= '0;
				cur_q   <= '0;
				trans_q <= '0;
			end
			if (cmd.follow) begin
				level_q <= level_q + 2'd1;
				cur_q   <= link_diff[PW-1:0];
			end
			if (cmd.link) begin
				level_q     <= level_q + 2'd1;
				cur_q       <= next_free_q[PW-1:0];
				next_free_q <= next_free_q + NFW'(1);
			end
			if (cmd.set_trans) trans_q <= {rd_q[ENTRY_W-1:OFF_W], va_q[OFF_W-1:0]};
			if (cmd.result) begin
				out_valid_q  <= 1'b1;
				out_status_q <= cmd.status;
				out_data_q   <= trans_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		sts              = '0;
		sts.clr_last     = (clr_cnt_q == AW'(DEPTH - 1));
		sts.zero_last    = (clr_cnt_q[IDX_W-1:0] == {IDX_W{1'b1}});
		sts.mode         = mode_q;
		sts.link_ok      = rd_q[0] && (link_diff < LW'(TABLE_PAGES));
		sts.leaf_present = rd_q[0];
		sts.pool_empty   = (next_free_q >= NFW'(TABLE_PAGES));
		sts.last_upper   = (level_q == 2'd2);
		sts.out_free     = !out_valid_q || out_ready;
	end

	assign out_valid      = out_valid_q;
	assign out_status     = out_status_q;
	assign out_translated = out_data_q;

endmodule

// ===== rtl/core/four_level_page_table_walker_top.sv =====
// Four-level page table walker: translate, map and unmap against a private table pool.
// After reset the block sweeps its table memory to zero, one entry a cycle, and holds
// s_axis_tready low meanwhile; table_base may be written during the sweep. One request
// word is worked at a time. Each upper level takes a read of the table memory and a
// check of the entry. A translate that reaches its leaf then reads and checks the leaf
// entry, and a map or unmap that finds all three upper levels writes its leaf; the last
// step loads the output register, and the next word can be accepted in the cycle after.
// A translate that meets an absent level, or a map or unmap that finds the pool used up,
// goes from that level's check straight to loading its result, and a word with the
// reserved mode goes from its first read straight to its result. Every level that map or
// unmap has to create adds a clear of the 512 entries of the new page and a write of the
// link. The output register lets the next word be accepted while a result still waits on
// m_axis_tready; the following result then waits for it to leave. A missing level is
// taken from the pool in order and never returned; once the pool is used up, map and
// unmap report status 2.
module four_level_page_table_walker_top #(
	parameter int TABLE_PAGES = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wr_en,
	input  logic [51:0]  cfg_wr_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// virt_addr [47:0], target_phys [99:48], entry_flags [163:100], zero [167:164]
	input  logic [167:0] s_axis_tdata,
	// mode [1:0]
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// translated [63:0]
	output logic [63:0]  m_axis_tdata,
	// status [1:0]
	output logic [1:0]   m_axis_tuser
);
	import fpw_pkg::*;

	fpw_cmd_t cmd;
	fpw_sts_t sts;

	fpw_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.s_ready (s_axis_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	fpw_dp #(
		.TABLE_PAGES (TABLE_PAGES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.mode           (s_axis_tuser),
		.virt_addr      (s_axis_tdata[47:0]),
		.target_phys    (s_axis_tdata[99:48]),
		.entry_flags    (s_axis_tdata[163:100]),
		.cmd            (cmd),
		.sts            (sts),
		.out_ready      (m_axis_tready),
		.out_valid      (m_axis_tvalid),
		.out_status     (m_axis_tuser),
		.out_translated (m_axis_tdata)
	);

`ifndef SYNTH
	// No request word may be taken while the table memory is still being swept.
	assert property (@(posedge clk) disable iff (!arst_n) cmd.clear |-> !s_axis_tready)
		else $error("request accepted during table clear");

	// A new level is only linked while the pool still has a free page.
	assert property (@(posedge clk) disable iff (!arst_n) cmd.link |-> !sts.pool_empty)
		else $error("level linked with an exhausted pool");

	// A result is only loaded when the previous one has left or is leaving.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.result |-> (!m_axis_tvalid || m_axis_tready))
		else $error("pending result overwritten");

	// Link and leaf writes never happen in the same cycle.
	assert property (@(posedge clk) disable iff (!arst_n) cmd.link |-> !cmd.wr_leaf)
		else $error("link and leaf written together");
`endif

endmodule
